FILE: hdl/sha_pkg.sv
// shared types, constants and round tables for the byte-stream sha-256 hasher
// no dependencies; imported by sha_ctrl, sha_dp and the top level
package sha_pkg;

  localparam int unsigned FILL_W   = 6;
  localparam int unsigned RND_W    = 6;
  localparam int unsigned WIDX_W   = 3;
  localparam int unsigned NWORDS   = 8;
  localparam int unsigned BLK_BITS = 512;

  localparam logic [FILL_W-1:0] FILL_LAST  = 6'd63;
  localparam logic [FILL_W-1:0] FILL_LEN   = 6'd56;
  localparam logic [RND_W-1:0]  RND_LAST   = 6'd63;
  localparam logic [WIDX_W-1:0] WIDX_LAST  = 3'd7;
  localparam logic [7:0]        PAD_MARKER = 8'h80;

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] HASH_IV [NWORDS] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  // source of the byte shifted into the block buffer
  typedef enum logic [1:0] {
    BSEL_DATA  = 2'd0,
    BSEL_PAD80 = 2'd1,
    BSEL_ZERO  = 2'd2,
    BSEL_LEN   = 2'd3
  } byte_sel_t;

  typedef struct packed {
    logic                  push;       // shift one byte into the block buffer
    byte_sel_t             sel;
    logic                  count_inc;  // message byte counter step
    logic                  round;      // one compression round
    logic [RND_W-1:0]      round_idx;
    logic                  add_hash;   // fold working variables into the hash
    logic                  clear;      // back to the initial vector
    logic [WIDX_W-1:0]     word_idx;   // digest word on the output
  } sha_cmd_t;

  typedef struct packed {
    logic [FILL_W-1:0] fill;
  } sha_stat_t;

endpackage

FILE: hdl/sha_ctrl.sv
// sequencer for the sha-256 hasher: input, padding, rounds, hash update, digest output
// depends on sha_pkg
module sha_ctrl (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  input  logic                      in_byte_valid,
  input  logic                      in_end_of_message,
  output logic                      in_ready,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [sha_pkg::WIDX_W-1:0] word_index,
  output logic                      last_word,
  input  sha_pkg::sha_stat_t        stat,
  output sha_pkg::sha_cmd_t         cmd
);
  import sha_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_PAD  = 5'b00010,
    S_RND  = 5'b00100,
    S_ADD  = 5'b01000,
    S_OUT  = 5'b10000
  } state_t;

  state_t              state_r, state_nxt;
  logic [RND_W-1:0]    rnd_r, rnd_nxt;
  logic [WIDX_W-1:0]   widx_r, widx_nxt;
  logic                fin_r, fin_nxt;       // message closed, finishing
  logic                pad80_r, pad80_nxt;   // marker byte placed
  logic                lenph_r, lenph_nxt;   // length bytes under way
  logic                lendone_r, lendone_nxt;
  logic                full;

  assign in_ready   = (state_r == S_IDLE);
  assign out_valid  = (state_r == S_OUT);
  assign word_index = widx_r;
  assign last_word  = (widx_r == WIDX_LAST);
  assign full       = (stat.fill == FILL_LAST);

  always_comb begin
    state_nxt     = state_r;
    rnd_nxt       = rnd_r;
    widx_nxt      = widx_r;
    fin_nxt       = fin_r;
    pad80_nxt     = pad80_r;
    lenph_nxt     = lenph_r;
    lendone_nxt   = lendone_r;
    cmd           = '0;
    cmd.sel       = BSEL_DATA;
    cmd.round_idx = rnd_r;
    cmd.word_idx  = widx_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.push      = in_byte_valid;
          cmd.count_inc = in_byte_valid;
          if (in_end_of_message) begin
            fin_nxt = 1'b1;
          end
          if (in_byte_valid && full) begin
            state_nxt = S_RND;
          end else if (in_end_of_message) begin
            state_nxt = S_PAD;
          end
        end
      end
      S_PAD: begin
        cmd.push = 1'b1;
        if (!pad80_r) begin
          cmd.sel = BSEL_PAD80;
        end else if (lenph_r || (stat.fill == FILL_LEN)) begin
          cmd.sel = BSEL_LEN;
        end else begin
          cmd.sel = BSEL_ZERO;
        end
        pad80_nxt = 1'b1;
        if (pad80_r && (stat.fill == FILL_LEN)) begin
          lenph_nxt = 1'b1;
        end
        if ((cmd.sel == BSEL_LEN) && full) begin
          lendone_nxt = 1'b1;
        end
        if (full) begin
          state_nxt = S_RND;
        end
      end
      S_RND: begin
        cmd.round = 1'b1;
        rnd_nxt   = rnd_r + 1'b1;
        if (rnd_r == RND_LAST) begin
          state_nxt = S_ADD;
        end
      end
      S_ADD: begin
        cmd.add_hash = 1'b1;
        if (!fin_r) begin
          state_nxt = S_IDLE;
        end else if (lendone_r) begin
          state_nxt = S_OUT;
        end else begin
          state_nxt = S_PAD;
        end
      end
      S_OUT: begin
        if (out_ready) begin
          widx_nxt = widx_r + 1'b1;
          if (widx_r == WIDX_LAST) begin
            cmd.clear   = 1'b1;
            state_nxt   = S_IDLE;
            fin_nxt     = 1'b0;
            pad80_nxt   = 1'b0;
            lenph_nxt   = 1'b0;
            lendone_nxt = 1'b0;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      rnd_r     <= '0;
      widx_r    <= '0;
      fin_r     <= 1'b0;
      pad80_r   <= 1'b0;
      lenph_r   <= 1'b0;
      lendone_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      rnd_r     <= rnd_nxt;
      widx_r    <= widx_nxt;
      fin_r     <= fin_nxt;
      pad80_r   <= pad80_nxt;
      lenph_r   <= lenph_nxt;
      lendone_r <= lendone_nxt;
    end
  end

endmodule

FILE: hdl/sha_dp.sv
// sha-256 datapath: block buffer doubling as schedule window, round logic, hash state
// depends on sha_pkg
module sha_dp (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [7:0]         in_data_byte,
  input  sha_pkg::sha_cmd_t  cmd,
  output sha_pkg::sha_stat_t stat,
  output logic [31:0]        digest_word
);
  import sha_pkg::*;

  logic [BLK_BITS-1:0] blk_r, blk_nxt;
  logic [31:0]         hash_r [NWORDS];
  logic [31:0]         hash_nxt [NWORDS];
  logic [31:0]         v_r [NWORDS];
  logic [31:0]         v_nxt [NWORDS];
  logic [FILL_W-1:0]   fill_r, fill_nxt;
  logic [63:0]         count_r, count_nxt;
  logic [63:0]         bit_len, len_sh;
  logic [7:0]          push_byte;
  logic [31:0]         w0, w1, w9, w14, sched;
  logic [31:0]         t1, t2;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    logic [63:0] d;
    d = {x, x} >> n;
    return d[31:0];
  endfunction

  function automatic logic [31:0] big_s0(input logic [31:0] x);
    return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic logic [31:0] big_s1(input logic [31:0] x);
    return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic logic [31:0] small_s0(input logic [31:0] x);
    return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] small_s1(input logic [31:0] x);
    return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

  assign stat.fill   = fill_r;
  assign digest_word = hash_r[cmd.word_idx];

  // window taps: word 0 is the oldest
  assign w0    = blk_r[511:480];
  assign w1    = blk_r[479:448];
  assign w9    = blk_r[223:192];
  assign w14   = blk_r[63:32];
  assign sched = w0 + small_s0(w1) + w9 + small_s1(w14);

  assign t1 = v_r[7] + big_s1(v_r[4]) + ((v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6]))
            + ROUND_K[cmd.round_idx] + w0;
  assign t2 = big_s0(v_r[0]) + ((v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]));

  // length bytes go out most significant first, at offsets 56 to 63
  assign bit_len = {count_r[60:0], 3'b000};
  assign len_sh  = bit_len << {fill_r[2:0], 3'b000};

  always_comb begin
    case (cmd.sel)
      BSEL_DATA:  push_byte = in_data_byte;
      BSEL_PAD80: push_byte = PAD_MARKER;
      BSEL_ZERO:  push_byte = 8'h00;
      BSEL_LEN:   push_byte = len_sh[63:56];
      default:    push_byte = 8'h00;
    endcase
  end

  always_comb begin
    blk_nxt   = blk_r;
    fill_nxt  = fill_r;
    count_nxt = count_r;
    hash_nxt  = hash_r;
    v_nxt     = v_r;
    if (cmd.push) begin
      blk_nxt  = {blk_r[BLK_BITS-9:0], push_byte};
      fill_nxt = fill_r + 1'b1;
      v_nxt    = hash_r;  // working variables start from the current hash
    end
    if (cmd.count_inc) begin
      count_nxt = count_r + 64'd1;
    end
    if (cmd.round) begin
      blk_nxt  = {blk_r[BLK_BITS-33:0], sched};
      v_nxt[7] = v_r[6];
      v_nxt[6] = v_r[5];
      v_nxt[5] = v_r[4];
      v_nxt[4] = v_r[3] + t1;
      v_nxt[3] = v_r[2];
      v_nxt[2] = v_r[1];
      v_nxt[1] = v_r[0];
      v_nxt[0] = t1 + t2;
    end
    if (cmd.add_hash) begin
      for (int i = 0; i < NWORDS; i++) begin
        hash_nxt[i] = hash_r[i] + v_r[i];
      end
    end
    if (cmd.clear) begin
      hash_nxt  = HASH_IV;
      fill_nxt  = '0;
      count_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hash_r  <= HASH_IV;
      fill_r  <= '0;
      count_r <= '0;
    end else begin
      hash_r  <= hash_nxt;
      fill_r  <= fill_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    blk_r <= blk_nxt;
    v_r   <= v_nxt;
  end

endmodule

FILE: hdl/sha256_byte_stream_hash.sv
// top level of the byte-stream sha-256 hasher
// depends on sha_pkg, sha_ctrl and sha_dp
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+---------------------------------------------
//  in_     | input     | in_valid / in_ready | in_data_byte, in_byte_valid, in_end_of_message
//  out_    | output    | out_valid/out_ready | out_digest_word, out_word_index, out_last_word
//
// a message byte is taken while idle; the 64th byte of a block starts a compression
// (64 rounds of the single round unit, one per cycle, then one hash update)
// closing a message pads one byte per cycle to the block end,
// with one or two compressions, then eight output transactions
// in_ready is high only while idle; the output stalls freely on out_ready
// synchronous active-low reset loads the initial vector and clears byte counts
module sha256_byte_stream_hash (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_byte_valid,
  input  logic        in_end_of_message,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_digest_word,
  output logic [2:0]  out_word_index,
  output logic        out_last_word
);
  import sha_pkg::*;

  sha_cmd_t  cmd;
  sha_stat_t stat;

  // sequencer: owns round count, padding phase and digest word index
  sha_ctrl u_ctrl (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_byte_valid     (in_byte_valid),
    .in_end_of_message (in_end_of_message),
    .in_ready          (in_ready),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .word_index        (out_word_index),
    .last_word         (out_last_word),
    .stat              (stat),
    .cmd               (cmd)
  );

  // datapath: block buffer / schedule window, working variables, hash state
  sha_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_data_byte (in_data_byte),
    .cmd          (cmd),
    .stat         (stat),
    .digest_word  (out_digest_word)
  );

  // no input taken while a digest is being delivered
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input accepted during digest output");

  // after the last digest word the block is ready for a new message
  a_back_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && out_last_word) |=> (in_ready && !out_valid))
    else $error("not idle after final digest word");

  // digest words come out in order without gaps
  a_word_order: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && !out_last_word) |=>
      (out_valid && (out_word_index == 3'($past(out_word_index) + 3'd1))))
    else $error("digest word sequence broken");

endmodule
